// File: sv/vqcb_pkg.sv
// Shared types and constants for the 2x2 vector quantizer block.
// Depends on nothing; design files use scoped names, the tb imports it.
package vqcb_pkg;

  // Default configuration of the codebook.
  localparam int CODEBOOK_ENTRIES_DEF = 64;
  localparam int SAMPLE_BITS_DEF      = 8;

  // Fixed field widths of the transactions.
  localparam int BLOCK_SAMPLES  = 4;
  localparam int FIELD_BITS     = 8;
  localparam int INDEX_OUT_BITS = 6;
  localparam int DIST_OUT_BITS  = 18;

  // Operating modes.
  localparam logic MODE_TRAIN  = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  // One input transaction: mode and four luma samples.
  typedef struct packed {
    logic                  mode;
    logic [FIELD_BITS-1:0] sample0;
    logic [FIELD_BITS-1:0] sample1;
    logic [FIELD_BITS-1:0] sample2;
    logic [FIELD_BITS-1:0] sample3;
  } vqcb_in_t;

  // One result transaction.
  typedef struct packed {
    logic [INDEX_OUT_BITS-1:0] best_index;
    logic [DIST_OUT_BITS-1:0]  best_distance;
    logic                      was_loaded;
  } vqcb_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch a new block and clear the search
    logic load;     // store the block as a new codeword and report it
    logic issue;    // read the next codeword for the search
    logic finish;   // write back the average in train mode and report
  } vqcb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;        // every codeword slot is loaded
    logic empty;       // no codeword is loaded yet
    logic issue_last;  // the read being issued is the last of the search
    logic pipe_busy;   // distance pipeline still holds codewords
  } vqcb_status_t;

endpackage

// File: sv/vqcb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module vqcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/vqcb_ctrl.sv
// Controller state machine of the vector quantizer: sequences load, search,
// pipeline drain and result. Depends on vqcb_pkg.
module vqcb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  mode,
  input  vqcb_pkg::vqcb_status_t status,
  output vqcb_pkg::vqcb_cmd_t    cmd,
  output logic                  busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.capture = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (mode == vqcb_pkg::MODE_TRAIN && !status.full) begin
            state_nxt = S_LOAD;
          end else if (mode == vqcb_pkg::MODE_ENCODE && status.empty) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/vqcb_dp.sv
// Datapath of the vector quantizer: block register, codebook RAM, fill count,
// two-stage distance pipeline, best-match tracking and result register.
// Depends on vqcb_pkg and vqcb_ram.
module vqcb_dp #(
  parameter int CODEBOOK_ENTRIES = vqcb_pkg::CODEBOOK_ENTRIES_DEF,
  parameter int SW               = vqcb_pkg::FIELD_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vqcb_pkg::vqcb_in_t     in_data,
  input  vqcb_pkg::vqcb_cmd_t    cmd,
  output vqcb_pkg::vqcb_status_t status,
  output logic                   out_valid,
  output vqcb_pkg::vqcb_out_t    out_data
);

  localparam int NS   = vqcb_pkg::BLOCK_SAMPLES;
  localparam int IW   = (CODEBOOK_ENTRIES > 1) ? $clog2(CODEBOOK_ENTRIES) : 1;
  localparam int FCW  = $clog2(CODEBOOK_ENTRIES + 1);
  localparam int WW   = NS * SW;
  localparam int SQW  = 2 * SW;
  localparam int DW   = SQW + 2;
  localparam int IOB  = vqcb_pkg::INDEX_OUT_BITS;
  localparam int DOB  = vqcb_pkg::DIST_OUT_BITS;
  localparam logic [FCW-1:0] CE_C = FCW'(CODEBOOK_ENTRIES);

  // Block and search control registers.
  logic           mode_r;
  logic [WW-1:0]  blk_r;
  logic [FCW-1:0] fill_r;
  logic [FCW-1:0] cnt_r;
  logic [FCW-1:0] lim_m1;

  // Distance pipeline.
  logic           v1_r;
  logic [IW-1:0]  tag1_r;
  logic           v2_r;
  logic [IW-1:0]  tag2_r;
  logic [WW-1:0]  word2_r;
  logic [SQW-1:0] sq_r   [NS];
  logic [SQW-1:0] sq_nxt [NS];
  logic [SW-1:0]  dif    [NS];
  logic [DW-1:0]  dist_sum;
  logic           take;

  // Best match so far.
  logic [IW-1:0]  bidx_r;
  logic [DW-1:0]  bd_r;
  logic [WW-1:0]  bword_r;
  logic [WW-1:0]  avg;

  // RAM ports.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] ram_rdata;

  // Result register.
  logic                out_valid_r;
  vqcb_pkg::vqcb_out_t out_r;

  // Samples of a new block, kept to the configured sample width.
  logic [WW-1:0] blk_in;
  assign blk_in = {in_data.sample3[SW-1:0], in_data.sample2[SW-1:0],
                   in_data.sample1[SW-1:0], in_data.sample0[SW-1:0]};

  // Search range ends at the full codebook in train mode, at the fill in encode.
  assign lim_m1 = FCW'(((mode_r == vqcb_pkg::MODE_ENCODE) ? fill_r : CE_C) - 1'b1);

  assign status.full       = (fill_r == CE_C);
  assign status.empty      = (fill_r == '0);
  assign status.issue_last = (cnt_r == lim_m1);
  assign status.pipe_busy  = v1_r || v2_r;

  // Stage one: absolute differences and squares per sample lane.
  always_comb begin
    for (int p = 0; p < NS; p++) begin
      if (blk_r[p*SW +: SW] >= ram_rdata[p*SW +: SW]) begin
        dif[p] = blk_r[p*SW +: SW] - ram_rdata[p*SW +: SW];
      end else begin
        dif[p] = ram_rdata[p*SW +: SW] - blk_r[p*SW +: SW];
      end
      sq_nxt[p] = SQW'(dif[p]) * SQW'(dif[p]);
    end
  end

  // Stage two: sum of squares and strict compare; entry 0 is always taken first.
  assign dist_sum = DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]) + DW'(sq_r[3]);
  assign take     = v2_r && ((tag2_r == '0) || (dist_sum < bd_r));

  // Floored average of the winning codeword and the block.
  always_comb begin
    for (int p = 0; p < NS; p++) begin
      avg[p*SW +: SW] = SW'(({1'b0, bword_r[p*SW +: SW]} + {1'b0, blk_r[p*SW +: SW]}) >> 1);
    end
  end

  // Write port: a new codeword at the fill slot, or the updated winner.
  assign ram_we    = cmd.load || (cmd.finish && mode_r == vqcb_pkg::MODE_TRAIN);
  assign ram_waddr = cmd.load ? fill_r[IW-1:0] : bidx_r;
  assign ram_wdata = cmd.load ? blk_r : avg;

  vqcb_ram #(
    .WIDTH(WW),
    .DEPTH(CODEBOOK_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.issue),
    .raddr(cnt_r[IW-1:0]),
    .rdata(ram_rdata)
  );

  // Control registers: fill count, pipeline valids and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        fill_r <= fill_r + 1'b1;
      end
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      out_valid_r <= cmd.load || cmd.finish;
    end
  end

  // Payload registers of the block, the search and the pipeline.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_data.mode;
      blk_r  <= blk_in;
      cnt_r  <= '0;
      bidx_r <= '0;
      bd_r   <= '0;
    end else begin
      if (cmd.issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (take) begin
        bidx_r  <= tag2_r;
        bd_r    <= dist_sum;
        bword_r <= word2_r;
      end
    end
    tag1_r  <= cnt_r[IW-1:0];
    tag2_r  <= tag1_r;
    word2_r <= ram_rdata;
    for (int p = 0; p < NS; p++) begin
      sq_r[p] <= sq_nxt[p];
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.best_index    <= IOB'(fill_r);
      out_r.best_distance <= '0;
      out_r.was_loaded    <= 1'b1;
    end else if (cmd.finish) begin
      out_r.best_index    <= IOB'(bidx_r);
      out_r.best_distance <= DOB'(bd_r);
      out_r.was_loaded    <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/vq_codebook_train_and_search_unit.sv
// Top level of the 2x2 vector quantizer with online codebook training.
// Depends on vqcb_pkg, vqcb_ctrl and vqcb_dp (which holds vqcb_ram).
//
//   Channel  Ports                    Handshake
//   input    start, busy, in_data     taken when start is high and busy is low
//   result   out_valid, out_data      one-cycle strobe, always taken
//
// A load in train mode passes from acceptance through the load state and the
// result register to the result strobe. A search reads one codeword per cycle
// from the codebook RAM, drains the distance pipeline and then reports.
// An encode on an empty codebook goes straight to the finish state.
// Reset is synchronous and active low; it clears the fill count, so the
// codebook counts as empty afterward. The result side cannot stall.
module vq_codebook_train_and_search_unit #(
  parameter int CODEBOOK_ENTRIES = vqcb_pkg::CODEBOOK_ENTRIES_DEF,
  parameter int SAMPLE_BITS      = vqcb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vqcb_pkg::vqcb_in_t  in_data,
  output logic                out_valid,
  output vqcb_pkg::vqcb_out_t out_data
);

  // Stored sample width: bits above the field width are never present.
  localparam int SW = (SAMPLE_BITS < vqcb_pkg::FIELD_BITS) ? SAMPLE_BITS
                                                           : vqcb_pkg::FIELD_BITS;

  vqcb_pkg::vqcb_cmd_t    cmd;
  vqcb_pkg::vqcb_status_t status;

  // Controller.
  vqcb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_data.mode),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath.
  vqcb_dp #(
    .CODEBOOK_ENTRIES(CODEBOOK_ENTRIES),
    .SW              (SW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

// File: tb/vq_codebook_train_and_search_unit_tb.sv
// Testbench for the 2x2 vector quantizer: directed and random blocks, each result checked
// against a codebook model that is kept in step with the accepted transactions.
// Depends on vqcb_pkg and vq_codebook_train_and_search_unit.
module vq_codebook_train_and_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vqcb_pkg::*;

  localparam int ENTRIES        = CODEBOOK_ENTRIES_DEF;
  localparam int DIST_SAT       = (1 << DIST_OUT_BITS) - 1;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int DRAIN_CYCLES   = 80;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  vqcb_in_t  in_data = '0;
  logic      out_valid;
  vqcb_out_t out_data;

  // Codebook model and the queue of predicted results.
  logic [FIELD_BITS-1:0] codebook_model [ENTRIES][BLOCK_SAMPLES];
  int                    loaded_count = 0;
  vqcb_out_t             expected_codes[$];
  int                    error_count = 0;
  int                    cycle_count = 0;
  bit                    back_to_back = 1'b0;

  vq_codebook_train_and_search_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("tb: mismatch in %s: got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  // Works out the result of one block and updates the codebook model.
  function automatic vqcb_out_t quantize_block(input vqcb_in_t blk);
    int        smp[BLOCK_SAMPLES];
    int        best_dist;
    int        best_idx;
    int        sq_sum;
    int        diff;
    vqcb_out_t res;
    smp[0] = blk.sample0;
    smp[1] = blk.sample1;
    smp[2] = blk.sample2;
    smp[3] = blk.sample3;
    res = '0;
    if (blk.mode == MODE_TRAIN && loaded_count < ENTRIES) begin
      // Still filling: the block becomes the next codeword.
      for (int p = 0; p < BLOCK_SAMPLES; p++)
        codebook_model[loaded_count][p] = FIELD_BITS'(smp[p]);
      res.best_index = loaded_count[INDEX_OUT_BITS-1:0];
      res.was_loaded = 1'b1;
      loaded_count++;
    end else if (loaded_count > 0) begin
      // Nearest loaded codeword; a strict compare keeps the lowest index on ties.
      best_dist = 0;
      best_idx  = 0;
      for (int n = 0; n < loaded_count; n++) begin
        sq_sum = 0;
        for (int p = 0; p < BLOCK_SAMPLES; p++) begin
          diff = smp[p] - int'(codebook_model[n][p]);
          sq_sum += diff * diff;
        end
        if (n == 0 || sq_sum < best_dist) begin
          best_dist = sq_sum;
          best_idx  = n;
        end
      end
      res.best_index    = best_idx[INDEX_OUT_BITS-1:0];
      res.best_distance = DIST_OUT_BITS'((best_dist > DIST_SAT) ? DIST_SAT : best_dist);
      // Training on a full codebook pulls the winner halfway to the block.
      if (blk.mode == MODE_TRAIN) begin
        for (int p = 0; p < BLOCK_SAMPLES; p++)
          codebook_model[best_idx][p] =
            FIELD_BITS'((int'(codebook_model[best_idx][p]) + smp[p]) >> 1);
      end
    end
    return res;
  endfunction

  function automatic vqcb_in_t make_block(input logic mode, input logic [7:0] s0,
                                          input logic [7:0] s1, input logic [7:0] s2,
                                          input logic [7:0] s3);
    vqcb_in_t blk;
    blk.mode    = mode;
    blk.sample0 = s0;
    blk.sample1 = s1;
    blk.sample2 = s2;
    blk.sample3 = s3;
    return blk;
  endfunction

  // Sample values biased toward the extremes and a small palette, so that
  // exact matches and ties show up often.
  function automatic logic [7:0] pick_sample();
    logic [7:0] palette[4];
    palette = '{8'h10, 8'h11, 8'h40, 8'h41};
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1: return palette[$urandom_range(0, 3)];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random block; now and then an exact copy of a loaded codeword.
  function automatic vqcb_in_t random_block(input logic mode);
    int n;
    if (loaded_count > 0 && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(0, loaded_count - 1);
      return make_block(mode, codebook_model[n][0], codebook_model[n][1],
                        codebook_model[n][2], codebook_model[n][3]);
    end
    return make_block(mode, pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endfunction

  // Sends one block after a random gap, or none back to back; records its prediction
  // on acceptance. Called right after a rising edge; returns at the accepting edge.
  task automatic send_block(input vqcb_in_t blk);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= blk;
    do @(posedge clk); while (busy);
    expected_codes.push_back(quantize_block(blk));
  endtask

  // Result checker: each strobe is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    vqcb_out_t want;
    if (rst_n && out_valid) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("unexpected result, index", out_data.best_index, 0);
      end else begin
        want = expected_codes.pop_front();
        if (out_data.best_index !== want.best_index)
          report_mismatch("best_index", out_data.best_index, want.best_index);
        if (out_data.best_distance !== want.best_distance)
          report_mismatch("best_distance", out_data.best_distance, want.best_distance);
        if (out_data.was_loaded !== want.was_loaded)
          report_mismatch("was_loaded", out_data.was_loaded, want.was_loaded);
      end
    end
  end

  // Encodes on an empty codebook, including the sample extremes.
  task automatic test_empty_codebook();
    send_block(make_block(MODE_ENCODE, 8'h00, 8'h00, 8'h00, 8'h00));
    send_block(make_block(MODE_ENCODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_block(make_block(MODE_ENCODE, 8'hA5, 8'h5A, 8'h0F, 8'hF0));
  endtask

  // Loads during the fill, with searches over the partial codebook:
  // largest distance, nearest choice, ties and duplicate codewords.
  task automatic test_partial_fill();
    send_block(make_block(MODE_TRAIN, 8'h00, 8'h00, 8'h00, 8'h00));
    send_block(make_block(MODE_ENCODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_block(make_block(MODE_TRAIN, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_block(make_block(MODE_ENCODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_block(make_block(MODE_ENCODE, 8'h00, 8'h00, 8'h00, 8'h00));
    send_block(make_block(MODE_ENCODE, 8'h80, 8'h80, 8'h80, 8'h80));
    send_block(make_block(MODE_TRAIN, 8'h10, 8'h10, 8'h10, 8'h10));
    send_block(make_block(MODE_TRAIN, 8'h14, 8'h14, 8'h14, 8'h14));
    send_block(make_block(MODE_ENCODE, 8'h12, 8'h12, 8'h12, 8'h12));
    send_block(make_block(MODE_TRAIN, 8'h10, 8'h10, 8'h10, 8'h10));
    send_block(make_block(MODE_ENCODE, 8'h10, 8'h10, 8'h10, 8'h10));
    send_block(make_block(MODE_ENCODE, 8'h00, 8'hFF, 8'h00, 8'hFF));
  endtask

  // Fills the rest of the codebook with random blocks, encodes mixed in.
  task automatic test_random_fill();
    while (loaded_count < ENTRIES)
      send_block(random_block(($urandom_range(0, 3) == 0) ? MODE_ENCODE : MODE_TRAIN));
  endtask

  // Training and encoding on a full codebook, odd sums for the floored average.
  task automatic test_full_codebook();
    send_block(make_block(MODE_TRAIN, 8'h00, 8'h00, 8'h00, 8'h00));
    send_block(make_block(MODE_TRAIN, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_block(make_block(MODE_TRAIN, 8'h80, 8'h7F, 8'h01, 8'hFE));
    send_block(make_block(MODE_ENCODE, 8'h80, 8'h7F, 8'h01, 8'hFE));
    send_block(make_block(MODE_ENCODE, codebook_model[ENTRIES-1][0],
                          codebook_model[ENTRIES-1][1], codebook_model[ENTRIES-1][2],
                          codebook_model[ENTRIES-1][3]));
    send_block(make_block(MODE_TRAIN, 8'h11, 8'h41, 8'hFF, 8'h00));
  endtask

  // Random mix of training and encoding, with stretches of back-to-back traffic.
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      send_block(random_block($urandom_range(0, 1) ? MODE_ENCODE : MODE_TRAIN));
    end
    back_to_back = 1'b0;
  endtask

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Main sequence.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_codebook();
    test_partial_fill();
    test_random_fill();
    test_full_codebook();
    test_random_mix(700);
    start <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
